[rtl/spq_pkg.sv]
// shared types, constants and ring arithmetic for the sorted-insert priority queue
// no dependencies; used by spq_ram users and sorted_insert_priority_queue
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int PRIO_W      = 4;
    localparam int OCC_W       = 5;
    localparam int STAT_W      = 2;
    localparam int ENTRY_W     = ID_W + PRIO_W;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_REM_DATA
    } state_t;

    // (base + offset) mod depth, offset at most QUEUE_DEPTH
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[rtl/spq_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module spq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/sorted_insert_priority_queue.sv]
// sorted-insert priority queue: sequencer, head/count registers and result register
// depends on spq_pkg and spq_ram
//
// usage
//   a request is taken at a rising edge with start high and busy low. cmd selects
//   insert (user_id, priority_req) or remove of the head entry. each request gives
//   exactly one result, shown for one cycle with done high: status, removed_id,
//   removed_priority and occupancy (entries held after the request)
// timing
//   entries sit sorted in one ring memory with one write and one registered read
//   port. an insert walks back from the tail, one memory entry per cycle: reading
//   the next entry overlaps writing the shifted one. refused requests and an
//   insert into an empty queue finish straight from idle, a remove passes through
//   ST_REM_DATA, an insert stays in ST_INS_CMP while it compares and shifts and,
//   if it shifts every entry, goes on to ST_INS_PLACE. busy stays high while the
//   walk runs; the next request may be taken in the same cycle that shows the previous result
// reset
//   rst_n clears head, count and the sequencer; the memory is not cleared since
//   only slots holding stored entries are ever read
// the receiver cannot stall: a result is dropped if not taken during its cycle
module sorted_insert_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [spq_pkg::ID_W-1:0]      user_id,
    input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
    output logic                          done,
    output logic [spq_pkg::STAT_W-1:0]    status,
    output logic [spq_pkg::ID_W-1:0]      removed_id,
    output logic [spq_pkg::PRIO_W-1:0]    removed_priority,
    output logic [spq_pkg::OCC_W-1:0]     occupancy
);

    // control state
    spq_pkg::state_t                 state_reg, state_next;
    logic [spq_pkg::IDX_W-1:0]       head_reg, head_next;
    logic [spq_pkg::CNT_W-1:0]       count_reg, count_next;
    // gap position (offset from head) during the insert walk
    logic [spq_pkg::CNT_W-1:0]       k_reg, k_next;
    logic                            done_reg, done_next;

    // payload of the request in flight and of the result
    logic [spq_pkg::ID_W-1:0]        uid_reg, uid_next;
    logic [spq_pkg::PRIO_W-1:0]      pr_reg, pr_next;
    spq_pkg::status_t                status_reg, status_next;
    logic [spq_pkg::ID_W-1:0]        rid_reg, rid_next;
    logic [spq_pkg::PRIO_W-1:0]      rpr_reg, rpr_next;

    // memory port
    logic                            wr_en;
    logic [spq_pkg::IDX_W-1:0]       wr_addr;
    spq_pkg::entry_t                 wr_data;
    logic                            rd_en;
    logic [spq_pkg::IDX_W-1:0]       rd_addr;
    logic [spq_pkg::ENTRY_W-1:0]     rd_raw;
    spq_pkg::entry_t                 rd_entry;

    logic                            accept;
    logic                            is_full;
    logic                            is_empty;
    logic                            stop_walk;
    spq_pkg::entry_t                 new_entry;

    assign accept    = start && !busy;
    assign is_full   = (count_reg >= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);
    assign rd_entry  = spq_pkg::entry_t'(rd_raw);
    // equal priorities stay behind the older entry
    assign stop_walk = (rd_entry.prio <= pr_reg);
    assign new_entry = '{id: uid_reg, prio: pr_reg};

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == spq_pkg::CMD_INSERT)
                    begin
                        if (!is_full && !is_empty)
                        begin
                            state_next = spq_pkg::ST_INS_CMP;
                        end
                    end
                    else if (!is_empty)
                    begin
                        state_next = spq_pkg::ST_REM_DATA;
                    end
                end
            end
            spq_pkg::ST_INS_CMP:
            begin
                if (stop_walk)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
                else if (k_reg == spq_pkg::CNT_W'(1))
                begin
                    state_next = spq_pkg::ST_INS_PLACE;
                end
            end
            spq_pkg::ST_INS_PLACE: state_next = spq_pkg::ST_IDLE;
            spq_pkg::ST_REM_DATA:  state_next = spq_pkg::ST_IDLE;
            default:               state_next = spq_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        done_next   = 1'b0;
        uid_next    = uid_reg;
        pr_next     = pr_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        rpr_next    = rpr_reg;
        wr_en       = 1'b0;
        wr_addr     = head_reg;
        wr_data     = new_entry;
        rd_en       = 1'b0;
        rd_addr     = head_reg;

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    uid_next = user_id;
                    pr_next  = priority_req;
                    rid_next = '0;
                    rpr_next = '0;
                    if (cmd == spq_pkg::CMD_INSERT)
                    begin
                        if (is_full)
                        begin
                            status_next = spq_pkg::STAT_FULL;
                            done_next   = 1'b1;
                        end
                        else if (is_empty)
                        begin
                            // first entry goes straight to the head slot
                            wr_en       = 1'b1;
                            wr_addr     = head_reg;
                            wr_data     = '{id: user_id, prio: priority_req};
                            count_next  = count_reg + spq_pkg::CNT_W'(1);
                            status_next = spq_pkg::STAT_DONE;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // gap at the tail, fetch the entry before it
                            k_next  = count_reg;
                            rd_en   = 1'b1;
                            rd_addr = spq_pkg::ring_pos(head_reg,
                                                        count_reg - spq_pkg::CNT_W'(1));
                        end
                    end
                    else if (is_empty)
                    begin
                        status_next = spq_pkg::STAT_EMPTY;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_reg;
                    end
                end
            end
            spq_pkg::ST_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = spq_pkg::ring_pos(head_reg, k_reg);
                if (stop_walk)
                begin
                    wr_data     = new_entry;
                    count_next  = count_reg + spq_pkg::CNT_W'(1);
                    status_next = spq_pkg::STAT_DONE;
                    done_next   = 1'b1;
                end
                else
                begin
                    // shift one place toward the tail, fetch the next one
                    wr_data = rd_entry;
                    k_next  = k_reg - spq_pkg::CNT_W'(1);
                    if (k_reg != spq_pkg::CNT_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = spq_pkg::ring_pos(head_reg,
                                                    k_reg - spq_pkg::CNT_W'(2));
                    end
                end
            end
            spq_pkg::ST_INS_PLACE:
            begin
                wr_en       = 1'b1;
                wr_addr     = head_reg;
                wr_data     = new_entry;
                count_next  = count_reg + spq_pkg::CNT_W'(1);
                status_next = spq_pkg::STAT_DONE;
                done_next   = 1'b1;
            end
            spq_pkg::ST_REM_DATA:
            begin
                rid_next    = rd_entry.id;
                rpr_next    = rd_entry.prio;
                head_next   = spq_pkg::ring_pos(head_reg, spq_pkg::CNT_W'(1));
                count_next  = count_reg - spq_pkg::CNT_W'(1);
                status_next = spq_pkg::STAT_DONE;
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uid_reg    <= uid_next;
        pr_reg     <= pr_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rpr_reg    <= rpr_next;
    end

    assign busy             = (state_reg != spq_pkg::ST_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_id       = rid_reg;
    assign removed_priority = rpr_reg;
    assign occupancy        = spq_pkg::OCC_W'(count_reg);

    // count never exceeds the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // the walk always has an entry in front of the gap
    a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::ST_INS_CMP) |-> (k_reg != '0))
        else $error("insert walk with empty gap offset");

    // remove on empty queue is refused at once and changes nothing
    a_empty_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == spq_pkg::CMD_REMOVE && is_empty) |=>
        (done_reg && status_reg == spq_pkg::STAT_EMPTY && count_reg == '0
         && head_reg == $past(head_reg)))
        else $error("empty remove not refused cleanly");

    // insert on full queue is refused at once and keeps the count
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == spq_pkg::CMD_INSERT && is_full) |=>
        (done_reg && status_reg == spq_pkg::STAT_FULL
         && count_reg == $past(count_reg)))
        else $error("full insert not refused cleanly");

    // a successful remove frees exactly one slot
    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::ST_REM_DATA) |=>
        (done_reg && count_reg == $past(count_reg) - spq_pkg::CNT_W'(1)))
        else $error("remove did not drop count by one");

endmodule
